// ===== rtl/core/hpm_pkg.sv =====
// Shared types and constants for the histogram percentile min/max block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package hpm_pkg;

	// Default sizing of the histogram store
	localparam int DEF_MAX_SAMPLE_BITS = 16;
	localparam int DEF_COUNT_WIDTH     = 32;

	// Fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int LEVEL_W    = 16;
	localparam int BITS_W     = 5;
	localparam int FRAC_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [BITS_W-1:0] MIN_BITS = 5'd8;
	localparam logic [FRAC_W-1:0] Q16_ONE  = 17'h10000;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_FRACTION  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FRACTION = 2'd2;

	// Scan direction
	localparam logic DIR_UP   = 1'b0;
	localparam logic DIR_DOWN = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic acc_rd;     // sample accepted: latch it, read its bin
		logic acc_wr;     // write back incremented bin, bump count
		logic tgt_lo;     // compute low target
		logic tgt_hi;     // compute high target
		logic scan_init;  // start a scan
		logic scan_dir;   // direction for scan_init
		logic scan_step;  // advance scan one bin
		logic clr_step;   // clear one bin
		logic out_load;   // load result into output register
	} hpm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;  // scan finishes this cycle
		logic clr_last;   // last bin being cleared this cycle
		logic out_free;   // output register can take a result
	} hpm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/hpm_ram.sv =====
// Generic single-port RAM: one address per cycle, write or registered read.
// No dependencies.
`default_nettype none

module hpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/hpm_ctrl.sv =====
// Controller for the histogram percentile min/max block.
// Sequences accumulation, target math, both scans, output and clearing; uses hpm_pkg.
`default_nettype none

module hpm_ctrl
	import hpm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	input  wire logic     s_tlast,
	output logic          s_tready,
	input  wire hpm_sts_t sts,
	output hpm_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_WR,
		ST_TGT_LO,
		ST_TGT_HI,
		ST_SCAN_LO,
		ST_SCAN_HI,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   last_q;

	assign s_tready = (state_q == ST_IDLE);

	// Command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR:   cmd.clr_step = 1'b1;
			ST_IDLE:    cmd.acc_rd = s_tvalid;
			ST_ACC_WR:  cmd.acc_wr = 1'b1;
			ST_TGT_LO:  cmd.tgt_lo = 1'b1;
			ST_TGT_HI: begin
				cmd.tgt_hi    = 1'b1;
				cmd.scan_init = 1'b1;
				cmd.scan_dir  = DIR_UP;
			end
			ST_SCAN_LO: begin
				cmd.scan_step = 1'b1;
				cmd.scan_init = sts.scan_done;
				cmd.scan_dir  = DIR_DOWN;
			end
			ST_SCAN_HI: cmd.scan_step = 1'b1;
			ST_OUT:     cmd.out_load = sts.out_free;
			default:    cmd = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						last_q  <= s_tlast;
						state_q <= ST_ACC_WR;
					end
				end
				ST_ACC_WR: begin
					state_q <= last_q ? ST_TGT_LO : ST_IDLE;
				end
				ST_TGT_LO:  state_q <= ST_TGT_HI;
				ST_TGT_HI:  state_q <= ST_SCAN_LO;
				ST_SCAN_LO: begin
					if (sts.scan_done) state_q <= ST_SCAN_HI;
				end
				ST_SCAN_HI: begin
					if (sts.scan_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_CLEAR;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/hpm_dp.sv =====
// Datapath for the histogram percentile min/max block: config registers,
// histogram RAM, sample count, target multiplier, scan engine, output register.
// Uses hpm_pkg and hpm_ram.
`default_nettype none

module hpm_dp
	import hpm_pkg::*;
#(
	parameter int MAX_SAMPLE_BITS = DEF_MAX_SAMPLE_BITS,
	parameter int COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [SAMPLE_W-1:0]   sample,
	input  wire hpm_cmd_t              cmd,
	output hpm_sts_t                   sts,
	input  wire logic                  m_tready,
	output logic                       m_tvalid,
	output logic [LEVEL_W-1:0]         low_level,
	output logic [LEVEL_W-1:0]         high_level
);

	localparam int ADDR_W = MAX_SAMPLE_BITS;
	localparam int DEPTH  = 2 ** MAX_SAMPLE_BITS;
	localparam int TGT_W  = COUNT_WIDTH + 1;
	localparam int PROD_W = COUNT_WIDTH + FRAC_W;
	localparam int SUM_W  = COUNT_WIDTH + MAX_SAMPLE_BITS;

	// Configuration registers
	logic [BITS_W-1:0] bits_q;
	logic [FRAC_W-1:0] lo_frac_q;
	logic [FRAC_W-1:0] hi_frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q    <= MIN_BITS;
			lo_frac_q <= '0;
			hi_frac_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SAMPLE_BITS:   bits_q    <= cfg_data[BITS_W-1:0];
				CFG_LOW_FRACTION:  lo_frac_q <= cfg_data[FRAC_W-1:0];
				CFG_HIGH_FRACTION: hi_frac_q <= cfg_data[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective bit count, top bin and clamped sample address
	logic [BITS_W-1:0]   eb_c;
	logic [ADDR_W-1:0]   top_c;
	logic [SAMPLE_W-1:0] clamp_c;

	always_comb begin
		if (bits_q < MIN_BITS) begin
			eb_c = MIN_BITS;
		end else if (bits_q > BITS_W'(MAX_SAMPLE_BITS)) begin
			eb_c = BITS_W'(MAX_SAMPLE_BITS);
		end else begin
			eb_c = bits_q;
		end
		top_c   = {ADDR_W{1'b1}} >> (BITS_W'(MAX_SAMPLE_BITS) - eb_c);
		clamp_c = (sample > SAMPLE_W'(top_c)) ? SAMPLE_W'(top_c) : sample;
	end

	// Histogram store
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_addr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [COUNT_WIDTH-1:0] ram_rdata;

	logic [ADDR_W-1:0] acc_addr_q;
	logic [ADDR_W-1:0] top_q;
	logic [ADDR_W-1:0] scan_addr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	hpm_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// RAM port arbitration by command
	always_comb begin
		ram_we    = cmd.acc_wr | cmd.clr_step;
		ram_wdata = '0;
		if (cmd.acc_wr) begin
			ram_wdata = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata
				: ram_rdata + COUNT_WIDTH'(1);
		end
		if (cmd.acc_rd) begin
			ram_addr = clamp_c[ADDR_W-1:0];
		end else if (cmd.acc_wr) begin
			ram_addr = acc_addr_q;
		end else if (cmd.scan_step) begin
			ram_addr = scan_addr_q;
		end else begin
			ram_addr = clr_addr_q;
		end
	end

	// Sample latch, frame count and clear sweep
	logic [COUNT_WIDTH-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_rd) begin
			acc_addr_q <= clamp_c[ADDR_W-1:0];
			top_q      <= top_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.acc_wr && cnt_q != {COUNT_WIDTH{1'b1}}) begin
				cnt_q <= cnt_q + COUNT_WIDTH'(1);
			end
			if (cmd.clr_step) begin
				cnt_q      <= '0;
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	assign sts.clr_last = cmd.clr_step && (clr_addr_q == {ADDR_W{1'b1}});

	// Targets: floor(count * fraction / 65536), one shared multiplier
	logic [FRAC_W-1:0] frac_c;
	logic [PROD_W-1:0] prod_c;
	logic [TGT_W-1:0]  tgt_lo_q;
	logic [TGT_W-1:0]  tgt_hi_q;

	always_comb begin
		frac_c = cmd.tgt_lo ? lo_frac_q : hi_frac_q;
		if (frac_c > Q16_ONE) frac_c = Q16_ONE;
		prod_c = PROD_W'(cnt_q) * PROD_W'(frac_c);
	end

	always_ff @(posedge clk) begin
		if (cmd.tgt_lo) tgt_lo_q <= prod_c[PROD_W-1:16];
		if (cmd.tgt_hi) tgt_hi_q <= prod_c[PROD_W-1:16];
	end

	// Scan engine: issue one bin per cycle, accumulate the bin read last cycle
	logic              dir_q;
	logic              issued_end_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              last_s1;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_next_c;
	logic [ADDR_W-1:0] end_addr_c;
	logic              hit_c;
	logic [ADDR_W-1:0] lv_c;
	logic [ADDR_W-1:0] low_lv_q;
	logic [ADDR_W-1:0] high_lv_q;

	always_comb begin
		end_addr_c = (dir_q == DIR_DOWN) ? '0 : top_q;
		sum_next_c = sum_q + SUM_W'(ram_rdata);
		hit_c      = sum_next_c > SUM_W'((dir_q == DIR_DOWN) ? tgt_hi_q : tgt_lo_q);
		if (hit_c) begin
			lv_c = addr_s1;
		end else begin
			lv_c = (dir_q == DIR_DOWN) ? '0 : top_q;
		end
	end

	assign sts.scan_done = cmd.scan_step && pend_s1 && (hit_c || last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1      <= 1'b0;
			issued_end_q <= 1'b0;
			dir_q        <= DIR_UP;
		end else begin
			pend_s1 <= cmd.scan_step && !issued_end_q;
			if (cmd.scan_step && !issued_end_q) begin
				issued_end_q <= (scan_addr_q == end_addr_c);
			end
			if (cmd.scan_init) begin
				pend_s1      <= 1'b0;
				issued_end_q <= 1'b0;
				dir_q        <= cmd.scan_dir;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && !issued_end_q) begin
			addr_s1     <= scan_addr_q;
			last_s1     <= (scan_addr_q == end_addr_c);
			scan_addr_q <= (dir_q == DIR_DOWN) ? scan_addr_q - ADDR_W'(1)
				: scan_addr_q + ADDR_W'(1);
		end
		if (cmd.scan_step && pend_s1) begin
			sum_q <= sum_next_c;
		end
		if (sts.scan_done) begin
			if (dir_q == DIR_DOWN) high_lv_q <= lv_c;
			else low_lv_q <= lv_c;
		end
		if (cmd.scan_init) begin
			sum_q       <= '0;
			scan_addr_q <= (cmd.scan_dir == DIR_DOWN) ? top_q : '0;
		end
	end

	// Output register
	logic               out_vld_q;
	logic [LEVEL_W-1:0] out_low_q;
	logic [LEVEL_W-1:0] out_high_q;

	assign sts.out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_low_q  <= LEVEL_W'(low_lv_q);
			out_high_q <= LEVEL_W'(high_lv_q);
		end
	end

	assign m_tvalid   = out_vld_q;
	assign low_level  = out_low_q;
	assign high_level = out_high_q;

endmodule

`default_nettype wire

// ===== rtl/core/histogram_percentile_min_max.sv =====
// Top level of the histogram percentile min/max block.
// Joins hpm_ctrl and hpm_dp; uses hpm_pkg.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready  | tdata[15:0] sample, tlast last_of_frame
//  m_      | out | m_tvalid / m_tready  | tdata[15:0] low_level, [31:16] high_level
//  cfg_    | in  | cfg_we               | cfg_index, cfg_data (no read-back)
//
// Each sample is a histogram RAM read, then the incremented write.
// Frame end adds the two target steps, an upward scan and a downward scan over
// at most 2^bits bins each, the output load, then a clearing pass over all
// 2^MAX_SAMPLE_BITS bins.
// After reset the same clearing pass runs first.
// s_tready is low during frame-end work and clearing, all on the single RAM port.
// A result held in the output register stalls only the next frame's end.
`default_nettype none

module histogram_percentile_min_max
	import hpm_pkg::*;
#(
	parameter int MAX_SAMPLE_BITS = DEF_MAX_SAMPLE_BITS,
	parameter int COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [15:0]           s_tdata,   // [15:0] sample
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [31:0]                m_tdata,   // [15:0] low_level, [31:16] high_level
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	hpm_cmd_t           cmd;
	hpm_sts_t           sts;
	logic [LEVEL_W-1:0] low_level;
	logic [LEVEL_W-1:0] high_level;

	hpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hpm_dp #(
		.MAX_SAMPLE_BITS (MAX_SAMPLE_BITS),
		.COUNT_WIDTH     (COUNT_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.low_level  (low_level),
		.high_level (high_level)
	);

	assign m_tdata = {high_level, low_level};

endmodule

`default_nettype wire

// ===== rtl/core/hpm_checker.sv =====
// Port-level checker for histogram_percentile_min_max, with its bind.
// Sees only the top-level ports; no package dependency.
`default_nettype none

module hpm_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// A stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// An accepted sample holds the input closed while its bin is written back
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sample accepted back to back");

	// A new result appears only while the input side is held off
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready)
		else $error("result loaded while input open");

	// A last sample is followed by frame-end work, never an immediate accept
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> ##1 !s_tready)
		else $error("input reopened right after frame end");

endmodule

bind histogram_percentile_min_max hpm_port_checks u_hpm_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/hpm_checker.sv =====
// Scoreboard for the histogram percentile min/max block: tracks the config port,
// predicts the clipped low/high levels of each frame and checks every result.
// Depends on hpm_pkg for widths, limits and register indexes.
`default_nettype none

module hpm_checker
	import hpm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [15:0]           s_tdata,   // [15:0] sample
	input  wire logic                  s_tlast,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [31:0]           m_tdata,   // [15:0] low_level, [31:16] high_level
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         levels_pending,
	output int                         levels_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] COUNT_SAT = 32'hFFFF_FFFF;
	localparam int          REPORT_MAX = 10;

	typedef struct packed {
		logic [LEVEL_W-1:0] high;
		logic [LEVEL_W-1:0] low;
	} levels_t;

	// Mirror of the block's registers and per-frame histogram
	logic [BITS_W-1:0] bits_q;
	logic [FRAC_W-1:0] low_frac_q;
	logic [FRAC_W-1:0] high_frac_q;
	logic [31:0]       bin_count [int];
	logic [31:0]       frame_samples;
	levels_t           levels_due [$];

	function automatic int used_bits(input logic [BITS_W-1:0] b);
		if (b < MIN_BITS)
			return int'(MIN_BITS);
		if (b > DEF_MAX_SAMPLE_BITS)
			return DEF_MAX_SAMPLE_BITS;
		return int'(b);
	endfunction

	function automatic longint unsigned used_frac(input logic [FRAC_W-1:0] f);
		return (f > Q16_ONE) ? longint'(Q16_ONE) : longint'(f);
	endfunction

	// Percentile levels of the frame held in bin_count.
	// Empty bins never move a running sum, so only filled bins are visited;
	// bins above the current top level lie outside the scan.
	function automatic levels_t clip_levels();
		int                top_lvl;
		longint unsigned   n;
		longint unsigned   low_target;
		longint unsigned   high_target;
		longint unsigned   run_sum;
		int                k;
		bit                hit;
		levels_t           lv;
		top_lvl     = (1 << used_bits(bits_q)) - 1;
		n           = frame_samples;
		low_target  = (n * used_frac(low_frac_q)) >> 16;
		high_target = (n * used_frac(high_frac_q)) >> 16;
		lv.low      = LEVEL_W'(top_lvl);
		lv.high     = '0;
		// upward scan
		run_sum = 0;
		hit     = 1'b0;
		if (bin_count.first(k)) begin
			do begin
				if (k <= top_lvl) begin
					run_sum += bin_count[k];
					if (run_sum > low_target) begin
						lv.low = LEVEL_W'(k);
						hit    = 1'b1;
					end
				end
			end while (!hit && bin_count.next(k));
		end
		// downward scan
		run_sum = 0;
		hit     = 1'b0;
		if (bin_count.last(k)) begin
			do begin
				if (k <= top_lvl) begin
					run_sum += bin_count[k];
					if (run_sum > high_target) begin
						lv.high = LEVEL_W'(k);
						hit     = 1'b1;
					end
				end
			end while (!hit && bin_count.prev(k));
		end
		return lv;
	endfunction

	task automatic report(input string what, input levels_t want, input levels_t got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%t ERROR %s: expected low=%0d high=%0d, got low=%0d high=%0d",
				$realtime, what, want.low, want.high, got.low, got.high);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		levels_t got;
		levels_t want;
		int      top_lvl;
		int      smp;
		if (!arst_n) begin
			bits_q         = MIN_BITS;
			low_frac_q     = '0;
			high_frac_q    = '0;
			frame_samples  = '0;
			fail_count     = 0;
			levels_pending = 0;
			levels_checked = 0;
			bin_count.delete();
			levels_due.delete();
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_BITS:   bits_q      = cfg_data[BITS_W-1:0];
					CFG_LOW_FRACTION:  low_frac_q  = cfg_data[FRAC_W-1:0];
					CFG_HIGH_FRACTION: high_frac_q = cfg_data[FRAC_W-1:0];
					default: ;
				endcase
			end

			// result transaction against the oldest expectation
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (levels_due.size() == 0) begin
					report("result with nothing pending", '0, got);
				end else begin
					want = levels_due.pop_front();
					levels_checked++;
					if (got.low !== want.low || got.high !== want.high)
						report("level mismatch", want, got);
				end
			end

			// sample transaction: clamp, count, and close the frame on tlast
			if (s_tvalid && s_tready) begin
				top_lvl = (1 << used_bits(bits_q)) - 1;
				smp     = int'(s_tdata);
				if (smp > top_lvl)
					smp = top_lvl;
				if (!bin_count.exists(smp))
					bin_count[smp] = '0;
				if (bin_count[smp] != COUNT_SAT)
					bin_count[smp]++;
				if (frame_samples != COUNT_SAT)
					frame_samples++;
				if (s_tlast) begin
					levels_due.push_back(clip_levels());
					bin_count.delete();
					frame_samples = '0;
				end
			end
			levels_pending = levels_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench top for histogram_percentile_min_max: clock, reset, sample stream,
// register settings, random backpressure and the verdict.
// Depends on hpm_pkg, the block's RTL and hpm_checker.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hpm_pkg::*;

	localparam int CLEAR_WAIT  = (1 << DEF_MAX_SAMPLE_BITS) + 64;
	localparam int STALL_LIMIT = 1_000_000;
	localparam int GAP_PCT     = 18;
	localparam int RAND_PHASES = 7;

	// index past the register list, written to check it is ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	bit                    clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;   // [15:0] sample
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;   // [15:0] low_level, [31:16] high_level
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int levels_pending;
	int levels_checked;
	int samples_sent = 0;
	int frames_sent  = 0;
	int quiet_cycles = 0;
	bit gaps_on      = 1'b1;

	histogram_percentile_min_max u_top (.*);

	hpm_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side: random stalls unless the quiet stretch is running
	always @(posedge clk)
		m_tready <= gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%t watchdog: %0d cycles without a transaction", $realtime, quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_sample(input logic [15:0] smp, input logic lst);
		while (gaps_on && $urandom_range(99) < GAP_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		samples_sent++;
		if (lst)
			frames_sent++;
	endtask

	// Hold the stream until every expected level pair has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (levels_pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Drain, let the clearing pass finish, then write all registers
	task automatic new_setting(input logic [BITS_W-1:0] bits, input logic [FRAC_W-1:0] lo,
			input logic [FRAC_W-1:0] hi);
		wait_drained();
		repeat (CLEAR_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SAMPLE_BITS;
		cfg_data  <= CFG_DATA_W'(bits);
		@(posedge clk);
		cfg_index <= CFG_LOW_FRACTION;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_HIGH_FRACTION;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data  <= CFG_DATA_W'($urandom_range(131071));
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [FRAC_W-1:0] pick_fraction();
		case ($urandom_range(5))
			0:       return '0;
			1:       return Q16_ONE;
			2:       return FRAC_W'($urandom_range(131071, 65537));
			default: return FRAC_W'($urandom_range(65536));
		endcase
	endfunction

	// One frame: full-range samples, in-range samples, or a tight cluster
	task automatic send_frame(input int len, input int top_lvl);
		int mode;
		int base;
		logic [15:0] smp;
		mode = $urandom_range(2);
		base = $urandom_range(top_lvl);
		for (int i = 0; i < len; i++) begin
			case (mode)
				0:       smp = 16'($urandom_range(65535));
				1:       smp = 16'($urandom_range(top_lvl));
				default: smp = 16'(base + $urandom_range(7));
			endcase
			send_sample(smp, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int phase_bits [RAND_PHASES];
		int ub;
		int frames;
		int len;
		phase_bits = '{7, 9, 12, 8, 10, 11, 17};
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings, single-sample frames and clamping
		send_sample(16'h0000, 1'b1);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'd3, 1'b0);
		send_sample(16'd200, 1'b0);
		send_sample(16'h1234, 1'b0);
		send_sample(16'd17, 1'b1);
		// fraction of one and above one: targets never exceeded
		new_setting(5'd8, Q16_ONE, 17'h1FFFF);
		send_sample(16'd10, 1'b0);
		send_sample(16'd20, 1'b0);
		send_sample(16'd30, 1'b1);
		// width below range, quarter and half fractions
		new_setting(5'd0, 17'd16384, 17'd32768);
		send_sample(16'd1, 1'b0);
		send_sample(16'd2, 1'b0);
		send_sample(16'd3, 1'b0);
		send_sample(16'd4, 1'b1);
		// width above range saturates to the full 16 bits
		new_setting(5'd31, 17'd0, 17'd0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h8000, 1'b1);
		new_setting(5'd16, Q16_ONE, Q16_ONE);
		send_sample(16'h00FF, 1'b0);
		send_sample(16'hFF00, 1'b1);

		// Random phases; widest width only once and briefly
		for (int p = 0; p < RAND_PHASES; p++) begin
			new_setting(BITS_W'(phase_bits[p]), pick_fraction(), pick_fraction());
			ub      = (phase_bits[p] < 8) ? 8 : (phase_bits[p] > 16) ? 16 : phase_bits[p];
			gaps_on = (p != 3);
			frames  = (p == RAND_PHASES - 1) ? 1 : 5;
			for (int f = 0; f < frames; f++) begin
				len = ($urandom_range(4) == 0) ? $urandom_range(3, 1) : $urandom_range(28, 4);
				send_frame(len, (1 << ub) - 1);
				if ($urandom_range(3) == 0)
					wait_drained();
			end
		end
		gaps_on = 1'b1;

		wait_drained();
		repeat (CLEAR_WAIT) @(posedge clk);
		$display("covered %0d samples in %0d frames, %0d level pairs checked",
			samples_sent, frames_sent, levels_checked);
		$display("widths 8..16 incl. out-of-range codes, fractions zero to past one, stalls on both sides");
		if (levels_pending != 0)
			$display("%0d expected results never arrived", levels_pending);
		if (fail_count == 0 && levels_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
